/* hdl/dlsu_pkg.sv */
// Shared types and constants for the DWARF line-state update block.
// It depends on nothing. Every other file in hdl/ uses it through scoped names.
package dlsu_pkg;

  // Standard opcode numbers as they arrive on the input channel.
  localparam logic [7:0] CMD_COPY          = 8'd1;
  localparam logic [7:0] CMD_ADVANCE_PC    = 8'd2;
  localparam logic [7:0] CMD_ADVANCE_LINE  = 8'd3;
  localparam logic [7:0] CMD_SET_FILE      = 8'd4;
  localparam logic [7:0] CMD_SET_COLUMN    = 8'd5;
  localparam logic [7:0] CMD_NEGATE_STMT   = 8'd6;
  localparam logic [7:0] CMD_SET_BLOCK     = 8'd7;
  localparam logic [7:0] CMD_CONST_ADD_PC  = 8'd8;
  localparam logic [7:0] CMD_FIXED_ADV_PC  = 8'd9;
  localparam logic [7:0] CMD_SET_PROLOGUE  = 8'd10;
  localparam logic [7:0] CMD_SET_EPILOGUE  = 8'd11;
  localparam logic [7:0] CMD_SET_ISA       = 8'd12;

  // Configuration register indexes.
  localparam logic [7:0] CFG_INSN_UNIT     = 8'd0;
  localparam logic [7:0] CFG_SPECIAL_BASE  = 8'd1;
  localparam logic [7:0] CFG_ADV_DIVISOR   = 8'd2;
  localparam logic [7:0] CFG_FILE_COUNT    = 8'd3;

  // Configuration reset values.
  localparam logic [7:0]  RST_INSN_UNIT    = 8'd1;
  localparam logic [7:0]  RST_SPECIAL_BASE = 8'd13;
  localparam logic [7:0]  RST_ADV_DIVISOR  = 8'd14;
  localparam logic [15:0] RST_FILE_COUNT   = 16'd0;

  // Highest opcode number; the constant pc advance is based on it.
  localparam logic [7:0] ADJ_TOP = 8'd255;

  // Divider length: one quotient bit per cycle.
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Decode queue between the front and the back.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Classified operation.
  typedef enum logic [3:0] {
    OP_UNKNOWN,
    OP_COPY,
    OP_ADVANCE_PC,
    OP_ADVANCE_LINE,
    OP_SET_FILE,
    OP_SET_COLUMN,
    OP_NEGATE_STMT,
    OP_SET_BLOCK,
    OP_CONST_ADD_PC,
    OP_FIXED_ADV_PC,
    OP_SET_PROLOGUE,
    OP_SET_EPILOGUE,
    OP_SET_ISA
  } op_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_APPLY
  } exec_state_t;

  typedef struct packed {
    logic [7:0]         cmd;
    logic signed [31:0] operand;
  } in_item_t;

  typedef struct packed {
    logic        row_valid;
    logic [63:0] row_address;
    logic [31:0] row_line;
    logic [31:0] row_file;
    logic [31:0] row_column;
    logic        stmt_flag;
    logic        block_flag;
    logic        prologue_flag;
    logic        epilogue_flag;
    logic [31:0] isa_value;
    logic        unknown_op;
  } out_item_t;

  // One decoded entry in the queue.
  typedef struct packed {
    op_t         op;
    logic [31:0] operand;
  } dec_item_t;

  // Configuration seen by the back end.
  typedef struct packed {
    logic [7:0]  insn_unit;
    logic [7:0]  special_base;
    logic [7:0]  adv_divisor;
    logic [15:0] file_count;
  } cfg_t;

  // Queue status toward a producer or consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hdl/dlsu_front.sv */
// Front end: accepts input items and classifies each opcode.
// Depends on dlsu_pkg; feeds dlsu_queue.
module dlsu_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dlsu_pkg::in_item_t    in_data,
  input  dlsu_pkg::q_status_t   q_status,
  output logic                  push,
  output dlsu_pkg::dec_item_t   push_data
);

  // An item is taken whenever the queue has room.
  assign in_ready = !q_status.full;
  assign push     = in_valid && !q_status.full;

  // Map the raw opcode to an operation class.
  always_comb begin
    push_data.operand = in_data.operand;
    case (in_data.cmd)
      dlsu_pkg::CMD_COPY:         push_data.op = dlsu_pkg::OP_COPY;
      dlsu_pkg::CMD_ADVANCE_PC:   push_data.op = dlsu_pkg::OP_ADVANCE_PC;
      dlsu_pkg::CMD_ADVANCE_LINE: push_data.op = dlsu_pkg::OP_ADVANCE_LINE;
      dlsu_pkg::CMD_SET_FILE:     push_data.op = dlsu_pkg::OP_SET_FILE;
      dlsu_pkg::CMD_SET_COLUMN:   push_data.op = dlsu_pkg::OP_SET_COLUMN;
      dlsu_pkg::CMD_NEGATE_STMT:  push_data.op = dlsu_pkg::OP_NEGATE_STMT;
      dlsu_pkg::CMD_SET_BLOCK:    push_data.op = dlsu_pkg::OP_SET_BLOCK;
      dlsu_pkg::CMD_CONST_ADD_PC: push_data.op = dlsu_pkg::OP_CONST_ADD_PC;
      dlsu_pkg::CMD_FIXED_ADV_PC: push_data.op = dlsu_pkg::OP_FIXED_ADV_PC;
      dlsu_pkg::CMD_SET_PROLOGUE: push_data.op = dlsu_pkg::OP_SET_PROLOGUE;
      dlsu_pkg::CMD_SET_EPILOGUE: push_data.op = dlsu_pkg::OP_SET_EPILOGUE;
      dlsu_pkg::CMD_SET_ISA:      push_data.op = dlsu_pkg::OP_SET_ISA;
      default:                    push_data.op = dlsu_pkg::OP_UNKNOWN;
    endcase
  end

endmodule

/* hdl/dlsu_queue.sv */
// Short FIFO of decoded items between the front end and the back end.
// Depends on dlsu_pkg.
module dlsu_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dlsu_pkg::dec_item_t   push_data,
  input  logic                  pop,
  output dlsu_pkg::dec_item_t   pop_data,
  output dlsu_pkg::q_status_t   status
);

  dlsu_pkg::dec_item_t              slots [dlsu_pkg::QDEPTH];
  logic [dlsu_pkg::QPTR_W-1:0]      wr_ptr;
  logic [dlsu_pkg::QPTR_W-1:0]      rd_ptr;
  logic [dlsu_pkg::QCNT_W-1:0]      count;

  assign status.full  = (count == dlsu_pkg::QCNT_W'(dlsu_pkg::QDEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = slots[rd_ptr];

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == dlsu_pkg::QPTR_W'(dlsu_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == dlsu_pkg::QPTR_W'(dlsu_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/dlsu_exec.sv */
// Back end: executes decoded items on the line-table registers and
// registers one result per item. Depends on dlsu_pkg; fed by dlsu_queue.
module dlsu_exec (
  input  logic                  clk,
  input  logic                  rst,
  input  dlsu_pkg::cfg_t        cfg,
  input  dlsu_pkg::q_status_t   q_status,
  input  dlsu_pkg::dec_item_t   q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dlsu_pkg::out_item_t   out_data
);

  dlsu_pkg::exec_state_t          state;
  dlsu_pkg::exec_state_t          state_next;

  // Current item.
  dlsu_pkg::op_t                  cur_op;
  logic [31:0]                    cur_opnd;

  // Serial divider and product register.
  logic [7:0]                     div_rem;
  logic [7:0]                     div_quo;
  logic [dlsu_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [8:0]                     rem_shift;
  logic                           rem_fits;
  logic [8:0]                     rem_sub;
  logic [31:0]                    mul_factor;
  logic [39:0]                    prod;

  // Line-table registers and their next values.
  logic [63:0] address_reg;
  logic [31:0] line_reg;
  logic [31:0] file_reg;
  logic [31:0] column_reg;
  logic        stmt_reg;
  logic        block_reg;
  logic        prologue_reg;
  logic        epilogue_reg;
  logic [31:0] isa_reg;

  logic [63:0] address_next;
  logic [31:0] line_next;
  logic [31:0] file_next;
  logic [31:0] column_next;
  logic        stmt_next;
  logic        block_next;
  logic        prologue_next;
  logic        epilogue_next;
  logic [31:0] isa_next;
  logic        row_valid_next;
  logic        unknown_next;
  logic [63:0] addr_delta;

  logic        fire;

  // Result is written when the output register is free or being drained.
  assign fire = (state == dlsu_pkg::S_APPLY) && (!out_valid || out_ready);

  // Sequencer: next state and queue pop.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      dlsu_pkg::S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          if (q_data.op == dlsu_pkg::OP_CONST_ADD_PC) begin
            state_next = dlsu_pkg::S_DIV;
          end else if (q_data.op == dlsu_pkg::OP_ADVANCE_PC) begin
            state_next = dlsu_pkg::S_MUL;
          end else begin
            state_next = dlsu_pkg::S_APPLY;
          end
        end
      end
      dlsu_pkg::S_DIV: begin
        if (div_cnt == dlsu_pkg::DIV_CNT_W'(dlsu_pkg::DIV_STEPS - 1)) begin
          state_next = dlsu_pkg::S_MUL;
        end
      end
      dlsu_pkg::S_MUL: begin
        state_next = dlsu_pkg::S_APPLY;
      end
      dlsu_pkg::S_APPLY: begin
        if (fire) begin
          state_next = dlsu_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dlsu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlsu_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring divider step: one quotient bit per cycle.
  assign rem_shift = {div_rem, div_quo[7]};
  assign rem_fits  = (rem_shift >= {1'b0, cfg.adv_divisor});
  assign rem_sub   = rem_shift - {1'b0, cfg.adv_divisor};

  // Multiplier operand: the quotient for a constant advance, else the operand.
  // A zero line range gives no advance.
  always_comb begin
    if (cur_op == dlsu_pkg::OP_CONST_ADD_PC) begin
      mul_factor = (cfg.adv_divisor == 8'd0) ? 32'd0 : {24'd0, div_quo};
    end else begin
      mul_factor = cur_opnd;
    end
  end

  // Item capture, divider and multiplier registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_op   <= q_data.op;
      cur_opnd <= q_data.operand;
      div_rem  <= '0;
      div_quo  <= dlsu_pkg::ADJ_TOP - cfg.special_base;
      div_cnt  <= '0;
    end else if (state == dlsu_pkg::S_DIV) begin
      div_rem  <= rem_fits ? rem_sub[7:0] : rem_shift[7:0];
      div_quo  <= {div_quo[6:0], rem_fits};
      div_cnt  <= div_cnt + 1'b1;
    end
    if (state == dlsu_pkg::S_MUL) begin
      prod <= {8'd0, mul_factor} * {32'd0, cfg.insn_unit};
    end
  end

  // Address increment for the opcodes that move the address.
  always_comb begin
    case (cur_op)
      dlsu_pkg::OP_ADVANCE_PC,
      dlsu_pkg::OP_CONST_ADD_PC: addr_delta = {24'd0, prod};
      dlsu_pkg::OP_FIXED_ADV_PC: addr_delta = {48'd0, cur_opnd[15:0]};
      default:                   addr_delta = 64'd0;
    endcase
  end

  // Register updates for the current item.
  always_comb begin
    address_next   = address_reg + addr_delta;
    line_next      = line_reg;
    file_next      = file_reg;
    column_next    = column_reg;
    stmt_next      = stmt_reg;
    block_next     = block_reg;
    prologue_next  = prologue_reg;
    epilogue_next  = epilogue_reg;
    isa_next       = isa_reg;
    row_valid_next = 1'b0;
    unknown_next   = 1'b0;
    case (cur_op)
      dlsu_pkg::OP_COPY: begin
        row_valid_next = (file_reg != 32'd0) && (file_reg <= {16'd0, cfg.file_count});
        block_next     = 1'b0;
      end
      dlsu_pkg::OP_ADVANCE_LINE: line_next     = line_reg + cur_opnd;
      dlsu_pkg::OP_SET_FILE:     file_next     = cur_opnd;
      dlsu_pkg::OP_SET_COLUMN:   column_next   = cur_opnd;
      dlsu_pkg::OP_NEGATE_STMT:  stmt_next     = !stmt_reg;
      dlsu_pkg::OP_SET_BLOCK:    block_next    = 1'b1;
      dlsu_pkg::OP_SET_PROLOGUE: prologue_next = 1'b1;
      dlsu_pkg::OP_SET_EPILOGUE: epilogue_next = 1'b1;
      dlsu_pkg::OP_SET_ISA:      isa_next      = cur_opnd;
      dlsu_pkg::OP_UNKNOWN:      unknown_next  = 1'b1;
      default: begin
        // Address-only opcodes: handled by the address increment.
      end
    endcase
  end

  // Line-table registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_reg  <= 64'd0;
      line_reg     <= 32'd1;
      file_reg     <= 32'd1;
      column_reg   <= 32'd0;
      stmt_reg     <= 1'b1;
      block_reg    <= 1'b0;
      prologue_reg <= 1'b0;
      epilogue_reg <= 1'b0;
      isa_reg      <= 32'd0;
    end else if (fire) begin
      address_reg  <= address_next;
      line_reg     <= line_next;
      file_reg     <= file_next;
      column_reg   <= column_next;
      stmt_reg     <= stmt_next;
      block_reg    <= block_next;
      prologue_reg <= prologue_next;
      epilogue_reg <= epilogue_next;
      isa_reg      <= isa_next;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.row_valid     <= row_valid_next;
      out_data.row_address   <= address_next;
      out_data.row_line      <= line_next;
      out_data.row_file      <= file_next;
      out_data.row_column    <= column_next;
      out_data.stmt_flag     <= stmt_next;
      out_data.block_flag    <= block_next;
      out_data.prologue_flag <= prologue_next;
      out_data.epilogue_flag <= epilogue_next;
      out_data.isa_value     <= isa_next;
      out_data.unknown_op    <= unknown_next;
    end
  end

  // The queue is only drained while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == dlsu_pkg::S_IDLE))
    else $error("queue popped outside idle state");

  // Only a constant pc advance runs the divider.
  assert property (@(posedge clk) disable iff (rst)
    (state == dlsu_pkg::S_DIV) |-> (cur_op == dlsu_pkg::OP_CONST_ADD_PC))
    else $error("divider running for a non-divide opcode");

  // A copy always leaves the basic-block flag clear.
  assert property (@(posedge clk) disable iff (rst)
    (fire && (cur_op == dlsu_pkg::OP_COPY)) |=> !block_reg)
    else $error("copy did not clear the basic-block flag");

  // A valid row never comes with the unknown-opcode flag.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.row_valid) |-> !out_data.unknown_op)
    else $error("row flagged valid on an unknown opcode");

endmodule

/* hdl/dwarf_line_state_update_core.sv */
// Top level of the DWARF line-state update block: configuration registers,
// front end, decode queue and back end. Depends on dlsu_pkg, dlsu_front,
// dlsu_queue and dlsu_exec.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one standard opcode and
//   its already-decoded operand per item. Output channel (out_valid/out_ready/
//   out_data) returns exactly one result per item, in order, with all
//   line-table registers as they stand after that opcode.
//   The configuration port (cfg_we/cfg_index/cfg_data) writes one register per
//   cycle and is meant to be used while no item is in flight.
// Timing:
//   The front end takes an item whenever the two-entry queue has room. With an
//   idle back end, an item passes the queue, the item capture and the output
//   register before out_valid rises; advance_pc adds a multiply state, and
//   const_add_pc a serial divider, then the multiply. The back end handles one
//   item at a time: it pops no new item until the last one's result is written.
// Reset (rst, synchronous): configuration and line-table registers return to
//   their defaults and the queue and output register empty.
// Stall: a result waits in the output register while out_ready is low; the
//   back end then holds, and input is accepted until the queue fills.
module dwarf_line_state_update_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dlsu_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dlsu_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  dlsu_pkg::cfg_t       cfg;
  dlsu_pkg::q_status_t  q_status;
  dlsu_pkg::dec_item_t  push_data;
  dlsu_pkg::dec_item_t  pop_data;
  logic                 push;
  logic                 pop;

  // Configuration registers; writes to other indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.insn_unit    <= dlsu_pkg::RST_INSN_UNIT;
      cfg.special_base <= dlsu_pkg::RST_SPECIAL_BASE;
      cfg.adv_divisor  <= dlsu_pkg::RST_ADV_DIVISOR;
      cfg.file_count   <= dlsu_pkg::RST_FILE_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        dlsu_pkg::CFG_INSN_UNIT:    cfg.insn_unit    <= cfg_data[7:0];
        dlsu_pkg::CFG_SPECIAL_BASE: cfg.special_base <= cfg_data[7:0];
        dlsu_pkg::CFG_ADV_DIVISOR:  cfg.adv_divisor  <= cfg_data[7:0];
        dlsu_pkg::CFG_FILE_COUNT:   cfg.file_count   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end: accept and classify.
  dlsu_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // Decode queue.
  dlsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // Back end: execute and register the result.
  dlsu_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_status  (q_status),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for dwarf_line_state_update_core: directed and random opcode streams
// checked against an in-bench line-table predictor. Depends on dlsu_pkg and the core.
module tb;

  // Opcode numbers outside the standard set.
  localparam logic [7:0] CMD_NONE         = 8'd0;
  localparam logic [7:0] CMD_FIRST_UNUSED = 8'd13;
  localparam logic [7:0] CMD_TOP          = 8'd255;

  // Register indexes that select nothing.
  localparam logic [7:0] CFG_INDEX_NONE = 8'd4;
  localparam logic [7:0] CFG_INDEX_TOP  = 8'd255;

  localparam int ITEMS_PER_PHASE = 250;
  localparam int DRAIN_CYCLES    = 16;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_LIMIT      = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  dlsu_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dlsu_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  dwarf_line_state_update_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted line-table registers and the configuration they run under.
  logic [63:0] pc_addr;
  logic [31:0] cur_line, cur_file, cur_col, cur_isa;
  logic        is_stmt, basic_blk, prologue, epilogue;
  logic [7:0]  lim_min_len, lim_op_base, lim_adv_div;
  logic [15:0] lim_file_count;

  dlsu_pkg::in_item_t  pending_ops[$];
  dlsu_pkg::out_item_t expected_rows[$];
  int items_total = 0;
  int items_taken = 0;
  int rows_seen = 0;
  int mismatches = 0;

  // Traffic shaping, set between phases.
  logic no_gaps = 1'b0;
  int   rx_mode = 1;
  int   burst_left = 1;
  int   gap_left = 0;
  int   hold_left = 0;
  int   rx_tick = 0;
  int   idle_cycles = 0;

  // Applies one opcode to the predicted registers and returns the row it yields.
  function automatic dlsu_pkg::out_item_t step_line_table(dlsu_pkg::in_item_t it);
    dlsu_pkg::out_item_t row;
    logic [31:0] opnd;
    logic [7:0] span;
    opnd = it.operand;
    row = '0;
    case (it.cmd)
      dlsu_pkg::CMD_COPY: begin
        row.row_valid = (cur_file >= 32'd1) && (cur_file <= {16'd0, lim_file_count});
        basic_blk = 1'b0;
      end
      dlsu_pkg::CMD_ADVANCE_PC:
        pc_addr = pc_addr + {32'd0, opnd} * {56'd0, lim_min_len};
      dlsu_pkg::CMD_ADVANCE_LINE: cur_line = cur_line + opnd;
      dlsu_pkg::CMD_SET_FILE:     cur_file = opnd;
      dlsu_pkg::CMD_SET_COLUMN:   cur_col = opnd;
      dlsu_pkg::CMD_NEGATE_STMT:  is_stmt = ~is_stmt;
      dlsu_pkg::CMD_SET_BLOCK:    basic_blk = 1'b1;
      dlsu_pkg::CMD_CONST_ADD_PC: begin
        span = dlsu_pkg::ADJ_TOP - lim_op_base;
        if (lim_adv_div != 8'd0) begin
          pc_addr = pc_addr + {56'd0, 8'(span / lim_adv_div)} * {56'd0, lim_min_len};
        end
      end
      dlsu_pkg::CMD_FIXED_ADV_PC: pc_addr = pc_addr + {48'd0, opnd[15:0]};
      dlsu_pkg::CMD_SET_PROLOGUE: prologue = 1'b1;
      dlsu_pkg::CMD_SET_EPILOGUE: epilogue = 1'b1;
      dlsu_pkg::CMD_SET_ISA:      cur_isa = opnd;
      default:                    row.unknown_op = 1'b1;
    endcase
    row.row_address   = pc_addr;
    row.row_line      = cur_line;
    row.row_file      = cur_file;
    row.row_column    = cur_col;
    row.stmt_flag     = is_stmt;
    row.block_flag    = basic_blk;
    row.prologue_flag = prologue;
    row.epilogue_flag = epilogue;
    row.isa_value     = cur_isa;
    return row;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: offers queued items in bursts; predicts each row as it is accepted.
  always @(posedge clk) begin : drive_items
    logic nv;
    dlsu_pkg::in_item_t nd;
    nv = in_valid;
    nd = in_data;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_rows.push_back(step_line_table(in_data));
        items_taken++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0 && !no_gaps) begin
          gap_left--;
        end else if (pending_ops.size() > 0) begin
          nd = pending_ops.pop_front();
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                   : $urandom_range(0, 3);
          end
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // Monitor: compares each row with the oldest prediction and paces out_ready.
  always @(posedge clk) begin : watch_rows
    dlsu_pkg::out_item_t want;
    logic nr;
    nr = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          $error("row arrived with no item outstanding");
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          check_field("row_valid", want.row_valid, out_data.row_valid);
          check_field("row_address", want.row_address, out_data.row_address);
          check_field("row_line", want.row_line, out_data.row_line);
          check_field("row_file", want.row_file, out_data.row_file);
          check_field("row_column", want.row_column, out_data.row_column);
          check_field("stmt_flag", want.stmt_flag, out_data.stmt_flag);
          check_field("block_flag", want.block_flag, out_data.block_flag);
          check_field("prologue_flag", want.prologue_flag, out_data.prologue_flag);
          check_field("epilogue_flag", want.epilogue_flag, out_data.epilogue_flag);
          check_field("isa_value", want.isa_value, out_data.isa_value);
          check_field("unknown_op", want.unknown_op, out_data.unknown_op);
        end
        rows_seen++;
        // Twice in the run, hold off long enough for the input side to back up.
        if (rows_seen == 400 || rows_seen == 1100) begin
          hold_left = HOLD_CYCLES;
        end
      end
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else begin
        case (rx_mode)
          0:       nr = 1'b1;
          1:       nr = ($urandom_range(0, 3) != 0);
          default: nr = ((rx_tick % 11) < 6);
        endcase
      end
    end
    out_ready <= nr;
  end

  // Watchdog: ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic add_item(logic [7:0] cmd, logic [31:0] opnd);
    dlsu_pkg::in_item_t it;
    it.cmd = cmd;
    it.operand = opnd;
    pending_ops.push_back(it);
    items_total++;
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dlsu_pkg::CFG_INSN_UNIT:    lim_min_len = val[7:0];
      dlsu_pkg::CFG_SPECIAL_BASE: lim_op_base = val[7:0];
      dlsu_pkg::CFG_ADV_DIVISOR:  lim_adv_div = val[7:0];
      dlsu_pkg::CFG_FILE_COUNT:   lim_file_count = val;
      default: ;
    endcase
  endtask

  // Writes all four registers; the 8-bit ones get random upper bits that must be dropped.
  task automatic set_config(logic [7:0] min_len, logic [7:0] op_base, logic [7:0] lrange,
                            logic [15:0] fcount);
    write_reg(dlsu_pkg::CFG_INSN_UNIT, {8'($urandom_range(0, 255)), min_len});
    write_reg(dlsu_pkg::CFG_SPECIAL_BASE, {8'($urandom_range(0, 255)), op_base});
    write_reg(dlsu_pkg::CFG_ADV_DIVISOR, {8'($urandom_range(0, 255)), lrange});
    write_reg(dlsu_pkg::CFG_FILE_COUNT, fcount);
  endtask

  task automatic wait_drained();
    while (items_taken != items_total || expected_rows.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(0, 16);
      4:       return -$urandom_range(1, 16);
      default: return $urandom;
    endcase
  endfunction

  // Random opcode mix: copies are frequent so that rows form, set_file mostly lands
  // near the file table, and a tenth of the items are unknown opcodes.
  task automatic add_random_item();
    int pick;
    logic [7:0] cmd;
    logic [31:0] opnd;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      cmd = ($urandom_range(0, 4) == 0) ? CMD_NONE
                                        : 8'($urandom_range(CMD_FIRST_UNUSED, CMD_TOP));
    end else if (pick < 30) begin
      cmd = dlsu_pkg::CMD_COPY;
    end else if (pick < 40) begin
      cmd = dlsu_pkg::CMD_SET_FILE;
    end else begin
      cmd = 8'($urandom_range(dlsu_pkg::CMD_COPY, dlsu_pkg::CMD_SET_ISA));
    end
    opnd = random_word();
    if (cmd == dlsu_pkg::CMD_SET_FILE && $urandom_range(0, 9) < 7) begin
      opnd = $urandom_range(0, int'(lim_file_count) + 2);
    end
    add_item(cmd, opnd);
  endtask

  initial begin : run_test
    int ph;
    // Reset state of the predicted registers and configuration.
    pc_addr = '0;
    cur_line = 32'd1;
    cur_file = 32'd1;
    cur_col = '0;
    cur_isa = '0;
    is_stmt = 1'b1;
    basic_blk = 1'b0;
    prologue = 1'b0;
    epilogue = 1'b0;
    lim_min_len = dlsu_pkg::RST_INSN_UNIT;
    lim_op_base = dlsu_pkg::RST_SPECIAL_BASE;
    lim_adv_div = dlsu_pkg::RST_ADV_DIVISOR;
    lim_file_count = dlsu_pkg::RST_FILE_COUNT;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset configuration.
    add_item(dlsu_pkg::CMD_COPY, 32'd0);
    add_item(dlsu_pkg::CMD_ADVANCE_PC, 32'hFFFF_FFFF);
    add_item(dlsu_pkg::CMD_ADVANCE_LINE, 32'hFFFF_FFFF);
    add_item(dlsu_pkg::CMD_ADVANCE_LINE, 32'h7FFF_FFFF);
    add_item(dlsu_pkg::CMD_ADVANCE_LINE, 32'h8000_0000);
    add_item(dlsu_pkg::CMD_CONST_ADD_PC, 32'hFFFF_FFFF);
    add_item(dlsu_pkg::CMD_FIXED_ADV_PC, 32'hFFFF_FFFF);
    add_item(dlsu_pkg::CMD_SET_FILE, 32'd0);
    add_item(dlsu_pkg::CMD_COPY, 32'd0);
    add_item(dlsu_pkg::CMD_SET_COLUMN, 32'hFFFF_FFFF);
    add_item(dlsu_pkg::CMD_NEGATE_STMT, 32'd0);
    add_item(dlsu_pkg::CMD_NEGATE_STMT, 32'd0);
    add_item(dlsu_pkg::CMD_SET_BLOCK, 32'd0);
    add_item(dlsu_pkg::CMD_COPY, 32'd0);
    add_item(dlsu_pkg::CMD_SET_PROLOGUE, 32'd0);
    add_item(dlsu_pkg::CMD_SET_EPILOGUE, 32'd0);
    add_item(dlsu_pkg::CMD_SET_ISA, 32'hFFFF_FFFF);
    add_item(CMD_NONE, 32'hFFFF_FFFF);
    add_item(CMD_FIRST_UNUSED, 32'd5);
    add_item(CMD_TOP, 32'h8000_0000);
    wait_drained();

    // Directed items around the top of the file table and largest multipliers.
    set_config(8'd255, 8'd0, 8'd255, 16'hFFFF);
    add_item(dlsu_pkg::CMD_SET_FILE, 32'h0000_FFFF);
    add_item(dlsu_pkg::CMD_COPY, 32'd0);
    add_item(dlsu_pkg::CMD_SET_FILE, 32'h0001_0000);
    add_item(dlsu_pkg::CMD_COPY, 32'd0);
    add_item(dlsu_pkg::CMD_CONST_ADD_PC, 32'd0);
    add_item(dlsu_pkg::CMD_ADVANCE_PC, 32'hFFFF_FFFF);
    wait_drained();

    // Random phases under differing configurations and traffic patterns.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(8'd0, 8'd255, 8'd0, 16'd0);
        1: set_config(8'd255, 8'd0, 8'd1, 16'hFFFF);
        2: set_config(dlsu_pkg::RST_INSN_UNIT, dlsu_pkg::RST_SPECIAL_BASE,
                      dlsu_pkg::RST_ADV_DIVISOR, 16'd4);
        default: begin
          set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)), 16'($urandom_range(0, 40)));
          // Writes to indexes that select no register must change nothing.
          write_reg(CFG_INDEX_NONE, 16'($urandom));
          write_reg(CFG_INDEX_TOP, 16'($urandom));
        end
      endcase
      no_gaps = (ph == 2);
      rx_mode = (ph == 2) ? 0 : (ph % 2) + 1;
      repeat (ITEMS_PER_PHASE) add_random_item();
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
